@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define MPCT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// a stalled transaction keeps valid high and its payload unchanged
`define MPCT_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

@@ hdl/mpct_pkg.sv @@
// ---------------------------------------------------------------------------
// mpct_pkg
// types and constants of the mouse packet cursor tracker
// ---------------------------------------------------------------------------
package mpct_pkg;

  localparam int CFG_W          = 13;
  localparam int CFG_IDX_W      = 2;
  localparam int COORD_BITS_DEF = 12;
  localparam int OUT_COORD_W    = 12;
  localparam int DX_W           = 9;
  localparam int DY_W           = 10;
  localparam int BTN_W          = 3;
  localparam int S_TDATA_W      = 8;
  localparam int M_TDATA_W      = 48;
  localparam int FIFO_DEPTH     = 2;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  // bit positions in the flag byte
  localparam int FLAG_SYNC_BIT  = 3;
  localparam int FLAG_XSIGN_BIT = 4;
  localparam int FLAG_YSIGN_BIT = 5;
  localparam int FLAG_XOVF_BIT  = 6;
  localparam int FLAG_YOVF_BIT  = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_XMOVE = 2'd1,
    PH_YMOVE = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] flag;
    logic [7:0] xmove;
    logic [7:0] ymove;
  } pkt_t;

endpackage

@@ hdl/mpct_frontend.sv @@
// ---------------------------------------------------------------------------
// mpct_frontend
// filters mouse bytes, keeps packet sync and assembles three-byte packets
// ---------------------------------------------------------------------------
module mpct_frontend (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          byte_valid_i,
  output logic          byte_ready_o,
  input  logic          from_aux_i,
  input  logic [7:0]    data_byte_i,
  output logic          pkt_valid_o,
  input  logic          pkt_ready_i,
  output mpct_pkg::pkt_t pkt_o
);
  import mpct_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] flag_q, flag_d;
  logic [7:0] xmove_q, xmove_d;
  logic       take;

  // a full queue stalls every byte, mouse or not
  assign byte_ready_o = pkt_ready_i;
  assign take         = byte_valid_i && byte_ready_o && from_aux_i;

  always_comb begin
    phase_d = phase_q;
    if (take) begin
      unique case (phase_q)
        PH_XMOVE: phase_d = PH_YMOVE;
        PH_YMOVE: phase_d = PH_FLAG;
        default: begin
          // resync: only a byte with the always-one bit may open a packet
          phase_d = data_byte_i[FLAG_SYNC_BIT] ? PH_XMOVE : PH_FLAG;
        end
      endcase
    end
  end

  always_comb begin
    flag_d      = flag_q;
    xmove_d     = xmove_q;
    pkt_valid_o = 1'b0;
    if (take) begin
      unique case (phase_q)
        PH_XMOVE: xmove_d = data_byte_i;
        PH_YMOVE: pkt_valid_o = 1'b1;
        default: begin
          if (data_byte_i[FLAG_SYNC_BIT]) begin
            flag_d = data_byte_i;
          end
        end
      endcase
    end
  end

  assign pkt_o.flag  = flag_q;
  assign pkt_o.xmove = xmove_q;
  assign pkt_o.ymove = data_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FLAG;
      flag_q  <= '0;
      xmove_q <= '0;
    end else begin
      phase_q <= phase_d;
      flag_q  <= flag_d;
      xmove_q <= xmove_d;
    end
  end

endmodule

@@ hdl/mpct_pkt_fifo.sv @@
// ---------------------------------------------------------------------------
// mpct_pkt_fifo
// short packet queue between the byte assembler and the cursor update
// ---------------------------------------------------------------------------
module mpct_pkt_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  mpct_pkg::pkt_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output mpct_pkg::pkt_t pop_data_o
);
  import mpct_pkg::*;

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(FIFO_DEPTH);

  pkt_t            mem_q [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != Full);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ hdl/mpct_backend.sv @@
// ---------------------------------------------------------------------------
// mpct_backend
// decodes a packet, moves and clamps the cursor, holds the event register
// ---------------------------------------------------------------------------
module mpct_backend #(
  parameter int CoordBits = mpct_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              pkt_valid_i,
  output logic                              pkt_ready_o,
  input  mpct_pkg::pkt_t                    pkt_i,
  input  logic [mpct_pkg::CFG_W-1:0]        screen_width_i,
  input  logic [mpct_pkg::CFG_W-1:0]        screen_height_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mpct_pkg::OUT_COORD_W-1:0]  cursor_x_o,
  output logic [mpct_pkg::OUT_COORD_W-1:0]  cursor_y_o,
  output logic signed [mpct_pkg::DX_W-1:0]  delta_x_o,
  output logic signed [mpct_pkg::DY_W-1:0]  delta_y_o,
  output logic [mpct_pkg::BTN_W-1:0]        buttons_o
);
  import mpct_pkg::*;

  localparam int ExtW = ((CoordBits > CFG_W) ? CoordBits : CFG_W) + 2;
  localparam logic [CoordBits-1:0] PosXReset = CoordBits'(WIDTH_RESET / 2);
  localparam logic [CoordBits-1:0] PosYReset = CoordBits'(HEIGHT_RESET / 2);

  typedef logic signed [ExtW-1:0] ext_t;

  function automatic logic [CoordBits-1:0] clamp_pos(ext_t p, logic [CFG_W-1:0] size);
    ext_t sz;
    ext_t lim;
    ext_t hi;
    ext_t r;
    sz  = ext_t'(size);
    lim = ext_t'(1) << CoordBits;
    // zero size pins the cursor at the origin; oversize saturates at the range
    if (sz == '0) begin
      hi = '0;
    end else if (sz > lim) begin
      hi = lim - ext_t'(1);
    end else begin
      hi = sz - ext_t'(1);
    end
    if (p < 0) begin
      r = '0;
    end else if (p > hi) begin
      r = hi;
    end else begin
      r = p;
    end
    return CoordBits'(r);
  endfunction

  logic [CoordBits-1:0]    pos_x_q, pos_x_d;
  logic [CoordBits-1:0]    pos_y_q, pos_y_d;
  logic                    out_valid_q, out_valid_d;
  logic [OUT_COORD_W-1:0]  cursor_x_q, cursor_y_q;
  logic signed [DX_W-1:0]  delta_x_q, delta_x_d;
  logic signed [DY_W-1:0]  delta_y_q, delta_y_d;
  logic [BTN_W-1:0]        buttons_q;
  logic signed [DX_W-1:0]  dy_mouse;
  logic                    ovf;
  logic                    take;

  assign pkt_ready_o = !out_valid_q || out_ready_i;
  assign take        = pkt_valid_i && pkt_ready_o;

  always_comb begin
    ovf       = pkt_i.flag[FLAG_XOVF_BIT] || pkt_i.flag[FLAG_YOVF_BIT];
    dy_mouse  = {pkt_i.flag[FLAG_YSIGN_BIT], pkt_i.ymove};
    delta_x_d = ovf ? '0 : {pkt_i.flag[FLAG_XSIGN_BIT], pkt_i.xmove};
    // screen y grows downward
    delta_y_d = ovf ? '0 : -DY_W'(dy_mouse);
    pos_x_d   = clamp_pos(ext_t'(pos_x_q) + ext_t'(delta_x_d), screen_width_i);
    pos_y_d   = clamp_pos(ext_t'(pos_y_q) + ext_t'(delta_y_d), screen_height_i);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_x_q     <= PosXReset;
      pos_y_q     <= PosYReset;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        pos_x_q <= pos_x_d;
        pos_y_q <= pos_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cursor_x_q <= OUT_COORD_W'(pos_x_d);
      cursor_y_q <= OUT_COORD_W'(pos_y_d);
      delta_x_q  <= delta_x_d;
      delta_y_q  <= delta_y_d;
      buttons_q  <= pkt_i.flag[BTN_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign cursor_x_o  = cursor_x_q;
  assign cursor_y_o  = cursor_y_q;
  assign delta_x_o   = delta_x_q;
  assign delta_y_o   = delta_y_q;
  assign buttons_o   = buttons_q;

endmodule

@@ hdl/mouse_packet_cursor_tracker_unit.sv @@
// ---------------------------------------------------------------------------
// mouse_packet_cursor_tracker_unit
// Takes one controller byte per cycle. Bytes not flagged as coming from the
// mouse are dropped; mouse bytes are gathered into three-byte packets, each
// of which yields one event with the clamped cursor position, the movement
// in screen orientation and the three buttons. The byte assembler hands a
// packet through a two-entry packet queue to the cursor update, whose
// combinational add and clamp loads the output register when the packet
// leaves the queue. Bytes are taken back to back; the input stalls only
// when the queue is full, which needs two packets waiting behind an event
// that the receiver holds off. The cursor starts at the screen centre; a
// new screen size takes effect on the next packet.
// ---------------------------------------------------------------------------
module mouse_packet_cursor_tracker_unit #(
  parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mpct_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [7:0] data_byte
  input  logic                             s_axis_tuser,  // [0] from_aux
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [11:0] cursor_x, [23:12] cursor_y, [32:24] delta_x, [42:33] delta_y,
  // [45:43] buttons, [47:46] zero
  output logic [mpct_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mpct_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mpct_pkg::CFG_W-1:0]       cfg_data_i
);
  import mpct_pkg::*;

  logic [CFG_W-1:0]       screen_width_q, screen_height_q;
  logic                   pkt_push_valid, pkt_push_ready;
  pkt_t                   pkt_push;
  logic                   pkt_pop_valid, pkt_pop_ready;
  pkt_t                   pkt_pop;
  logic [OUT_COORD_W-1:0] cursor_x, cursor_y;
  logic signed [DX_W-1:0] delta_x;
  logic signed [DY_W-1:0] delta_y;
  logic [BTN_W-1:0]       buttons;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= WIDTH_RESET;
      screen_height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        REG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mpct_frontend u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .from_aux_i   (s_axis_tuser),
    .data_byte_i  (s_axis_tdata),
    .pkt_valid_o  (pkt_push_valid),
    .pkt_ready_i  (pkt_push_ready),
    .pkt_o        (pkt_push)
  );

  mpct_pkt_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (pkt_push_valid),
    .push_ready_o (pkt_push_ready),
    .push_data_i  (pkt_push),
    .pop_valid_o  (pkt_pop_valid),
    .pop_ready_i  (pkt_pop_ready),
    .pop_data_o   (pkt_pop)
  );

  mpct_backend #(
    .CoordBits (COORD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pkt_valid_i     (pkt_pop_valid),
    .pkt_ready_o     (pkt_pop_ready),
    .pkt_i           (pkt_pop),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .cursor_x_o      (cursor_x),
    .cursor_y_o      (cursor_y),
    .delta_x_o       (delta_x),
    .delta_y_o       (delta_y),
    .buttons_o       (buttons)
  );

  assign m_axis_tdata = {2'b00, buttons, delta_y, delta_x, cursor_y, cursor_x};

endmodule

@@ hdl/mpct_checker.sv @@
// ---------------------------------------------------------------------------
// mpct_checker
// port-level checks on the cursor tracker, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mpct_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [mpct_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_o,
  input  logic [mpct_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mpct_pkg::CFG_W-1:0]       cfg_data_i
);
  import mpct_pkg::*;

  logic [CFG_W-1:0]       width_q, height_q;
  logic [OUT_COORD_W-1:0] evt_x, evt_y;
  logic [DY_W-1:0]        evt_dy;
  logic                   x_ok, y_ok;

  assign evt_x  = m_axis_tdata[11:0];
  assign evt_y  = m_axis_tdata[23:12];
  assign evt_dy = m_axis_tdata[42:33];

  // a zero size still leaves the cursor at the origin
  assign x_ok = (CFG_W'(evt_x) < width_q) || (evt_x == '0);
  assign y_ok = (CFG_W'(evt_y) < height_q) || (evt_y == '0);

  // shadow copy of the screen size as written on the config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_SCREEN_WIDTH) begin
        width_q <= cfg_data_i;
      end else if (cfg_index_i == REG_SCREEN_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  `MPCT_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, m_axis_tdata, "unstable")

  `MPCT_ASSERT(a_no_event_after_reset, clk_i, rst_ni, !$past(rst_ni) |-> !m_axis_tvalid, "early event")

  `MPCT_ASSERT(a_x_on_screen, clk_i, rst_ni, m_axis_tvalid |-> x_ok, "cursor x off screen")

  `MPCT_ASSERT(a_y_on_screen, clk_i, rst_ni, m_axis_tvalid |-> y_ok, "cursor y off screen")

  `MPCT_ASSERT(a_dy_range, clk_i, rst_ni, m_axis_tvalid |-> (evt_dy != 10'h200), "dy out of range")

endmodule

bind mouse_packet_cursor_tracker_unit mpct_checker u_mpct_checker (.*);

@@ tb/sv/mouse_packet_cursor_tracker_unit_tb.sv @@
// ---------------------------------------------------------------------------
// mouse_packet_cursor_tracker_unit_tb
// Sends tagged controller bytes into the tracker and checks every cursor
// event against an in-bench model of packet assembly, resync, overflow
// handling and clamping. Screen sizes are changed between phases, both
// stream sides idle at random and the event side holds off once for long.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module mouse_packet_cursor_tracker_unit_tb;
  import mpct_pkg::*;

  localparam int HOLD_CYCLES        = 80;
  localparam int SETTLE_CYCLES      = 8;
  localparam int TAIL_CYCLES        = 10;
  localparam int WATCHDOG_LIMIT     = 2000;
  localparam int RANDOM_PER_SETTING = 45;
  localparam int N_SETTINGS         = 8;
  localparam int COORD_LIMIT        = 1 << COORD_BITS_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic       aux;
    logic [7:0] data;
  } ctl_byte_t;

  typedef struct packed {
    logic [OUT_COORD_W-1:0] cursor_x;
    logic [OUT_COORD_W-1:0] cursor_y;
    logic [DX_W-1:0]        delta_x;
    logic [DY_W-1:0]        delta_y;
    logic [BTN_W-1:0]       buttons;
  } cursor_evt_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  ctl_byte_t   byte_q[$];
  cursor_evt_t cursor_q[$];

  // model state
  phase_e                 pkt_phase = PH_FLAG;
  logic [7:0]             flag_q    = '0;
  logic [7:0]             xmove_q   = '0;
  logic [OUT_COORD_W-1:0] cur_x     = OUT_COORD_W'(WIDTH_RESET / 2);
  logic [OUT_COORD_W-1:0] cur_y     = OUT_COORD_W'(HEIGHT_RESET / 2);
  logic [CFG_W-1:0]       scr_w     = WIDTH_RESET;
  logic [CFG_W-1:0]       scr_h     = HEIGHT_RESET;

  bit s_taken       = 1'b0;
  bit rx_hold_phase = 1'b0;
  bit no_idle       = 1'b0;
  int hold_count    = 0;
  int idle_cycles   = 0;
  int err_count     = 0;

  logic [CFG_W-1:0] width_set [N_SETTINGS] =
    '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd4097, 13'd100, 13'd640, 13'd320};
  logic [CFG_W-1:0] height_set [N_SETTINGS] =
    '{13'd1, 13'd4096, 13'd8191, 13'd0, 13'd4095, 13'd37, 13'd480, 13'd200};

  mouse_packet_cursor_tracker_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [OUT_COORD_W-1:0] clamp_coord(input int p,
                                                         input logic [CFG_W-1:0] size);
    int lim;
    if (size == 0) lim = 1;
    else if (size > COORD_LIMIT) lim = COORD_LIMIT;
    else lim = size;
    if (p < 0) p = 0;
    if (p >= lim) p = lim - 1;
    return p[OUT_COORD_W-1:0];
  endfunction

  task automatic track_byte(input logic aux, input logic [7:0] b);
    int          dx;
    int          dy;
    int          ndy;
    cursor_evt_t evt;
    if (!aux) return;
    case (pkt_phase)
      PH_XMOVE: begin
        xmove_q   = b;
        pkt_phase = PH_YMOVE;
      end
      PH_YMOVE: begin
        pkt_phase = PH_FLAG;
        dx = xmove_q;
        dy = b;
        if (flag_q[FLAG_XSIGN_BIT]) dx -= 256;
        if (flag_q[FLAG_YSIGN_BIT]) dy -= 256;
        if (flag_q[FLAG_XOVF_BIT] || flag_q[FLAG_YOVF_BIT]) begin
          dx = 0;
          dy = 0;
        end
        // screen y grows downward
        cur_x = clamp_coord(int'(cur_x) + dx, scr_w);
        cur_y = clamp_coord(int'(cur_y) - dy, scr_h);
        ndy = -dy;
        evt.cursor_x = cur_x;
        evt.cursor_y = cur_y;
        evt.delta_x  = dx[DX_W-1:0];
        evt.delta_y  = ndy[DY_W-1:0];
        evt.buttons  = flag_q[BTN_W-1:0];
        cursor_q.push_back(evt);
      end
      default: begin
        // without the sync bit the byte cannot open a packet
        if (b[FLAG_SYNC_BIT]) begin
          flag_q    = b;
          pkt_phase = PH_XMOVE;
        end else begin
          pkt_phase = PH_FLAG;
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [M_TDATA_W-1:0] got,
                                 input logic [M_TDATA_W-1:0] want);
    err_count++;
    $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  task automatic check_event(input logic [M_TDATA_W-1:0] d);
    cursor_evt_t want;
    if (cursor_q.size() == 0) begin
      report_mismatch("event with none pending", d, '0);
      return;
    end
    want = cursor_q.pop_front();
    if (d[11:0] != want.cursor_x) report_mismatch("cursor_x", d[11:0], want.cursor_x);
    if (d[23:12] != want.cursor_y) report_mismatch("cursor_y", d[23:12], want.cursor_y);
    if (d[32:24] != want.delta_x) report_mismatch("delta_x", d[32:24], want.delta_x);
    if (d[42:33] != want.delta_y) report_mismatch("delta_y", d[42:33], want.delta_y);
    if (d[45:43] != want.buttons) report_mismatch("buttons", d[45:43], want.buttons);
    if (d[47:46] != 2'b00) report_mismatch("tdata padding", d[47:46], '0);
  endtask

  // byte sender
  always @(negedge clk_i) begin
    ctl_byte_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_taken) begin
      if (byte_q.size() != 0 && (no_idle || $urandom_range(99) >= 30)) begin
        nxt = byte_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.data;
        s_axis_tuser  <= nxt.aux;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // event receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold_phase && hold_count < HOLD_CYCLES) begin
      m_axis_tready <= 1'b0;
      hold_count++;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 30);
    end
  end

  // transaction monitor, model update and watchdog
  always @(posedge clk_i) begin
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        case (cfg_index_i)
          REG_SCREEN_WIDTH:  scr_w = cfg_data_i;
          REG_SCREEN_HEIGHT: scr_h = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        check_event(m_axis_tdata);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        track_byte(s_axis_tuser, s_axis_tdata);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
    s_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  task automatic push_byte(input logic aux, input logic [7:0] b);
    ctl_byte_t item;
    item.aux  = aux;
    item.data = b;
    byte_q.push_back(item);
  endtask

  task automatic push_packet(input logic [7:0] flag, input logic [7:0] xb,
                             input logic [7:0] yb);
    push_byte(1'b1, flag);
    push_byte(1'b1, xb);
    push_byte(1'b1, yb);
  endtask

  // mostly whole packets with random content, some stray and foreign bytes
  task automatic push_random(input int n);
    int         cnt;
    int         r;
    logic [7:0] pb [3];
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(99);
      if (r < 10) begin
        push_byte(1'b0, 8'($urandom));
      end else if (r < 22) begin
        push_byte(1'b1, 8'($urandom));
        cnt++;
      end else begin
        pb[0] = 8'($urandom);
        pb[0][FLAG_SYNC_BIT] = 1'b1;
        if ($urandom_range(9) != 0) pb[0][FLAG_YOVF_BIT:FLAG_XOVF_BIT] = 2'b00;
        pb[1] = 8'($urandom);
        pb[2] = 8'($urandom);
        for (int k = 0; k < 3; k++) begin
          if ($urandom_range(7) == 0) push_byte(1'b0, 8'($urandom));
          push_byte(1'b1, pb[k]);
        end
        cnt += 3;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // sender pauses until every pending event is back, then the pipe settles
  task automatic wait_drained();
    do @(posedge clk_i);
    while (byte_q.size() != 0 || s_axis_tvalid || cursor_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_SCREEN_WIDTH;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: foreign bytes, lost sync, sign and overflow corners, clamping
    push_byte(1'b0, 8'hFF);
    push_byte(1'b1, 8'h00);
    push_byte(1'b1, 8'hF7);
    push_packet(8'h08, 8'h00, 8'h00);
    push_packet(8'h0F, 8'hFF, 8'h00);
    push_packet(8'h18, 8'h00, 8'hFF);
    push_packet(8'h28, 8'h01, 8'h00);
    push_packet(8'hF8, 8'hAA, 8'h55);
    push_packet(8'h49, 8'h7F, 8'h7F);
    push_packet(8'h8A, 8'h80, 8'h80);
    push_byte(1'b1, 8'h0C);
    push_byte(1'b0, 8'h08);
    push_byte(1'b1, 8'hFF);
    push_byte(1'b0, 8'hFF);
    push_byte(1'b1, 8'h80);
    push_packet(8'h08, 8'hFF, 8'h00);
    wait_drained();

    for (int ph = 0; ph < N_SETTINGS; ph++) begin
      if (ph == N_SETTINGS - 1) begin
        width_set[ph]  = 13'($urandom_range(1, COORD_LIMIT));
        height_set[ph] = 13'($urandom_range(1, COORD_LIMIT));
      end
      write_reg(REG_SCREEN_WIDTH, width_set[ph]);
      write_reg(REG_SCREEN_HEIGHT, height_set[ph]);
      if (ph == 4) write_reg(REG_UNUSED, 13'h1ABC);
      rx_hold_phase = (ph == 1);
      no_idle       = (ph == 3);
      push_random(RANDOM_PER_SETTING);
      wait_drained();
      rx_hold_phase = 1'b0;
      no_idle       = 1'b0;
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (err_count == 0 && cursor_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
